// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the deque with value search.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// File: rtl/dqs_pkg.sv
// Package for the deque with value search: field widths, operation and
// status codes, sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dqs_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int FUNC_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_SEARCH     = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_EMPTY     = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } state_t;

endpackage

`default_nettype wire

// File: rtl/deque_with_value_search.sv
// Top level of the deque with value search: stream ports, sequencer, shared
// comparator. Depends on dqs_pkg, dqs_ram and assert_macros.svh.
//   A bounded double-ended queue of signed 32-bit values, held as a ring of
//   DEPTH slots with a front pointer and an entry count.
//   Requests arrive on the s_ channel: s_tuser carries the operation (push
//   front, push back, pop front, pop back, search), s_tdata the value.
//   Each request yields exactly one transaction on the m_ channel: m_tuser
//   carries the status, m_tdata the match position and the entry count.
//   For pushes, pops and unused codes the queue is updated at the accepting
//   edge; the result is loaded into the output register from the result step
//   once that register is free. A search runs one stored entry per cycle
//   through a single 32-bit comparator fed by the registered read port of the
//   ring memory, front entry first, and stops at the first match or at the
//   last live entry; an empty search goes straight to the result step.
//   s_tready is high only while the sequencer is idle.
//   A result waiting in the output register does not block a new request;
//   a second result waits in the sequencer until m_tready frees the register.
//   aresetn (synchronous, active low) empties the queue, returns the front
//   pointer to slot 0 and drops any pending result. No clearing pass is run:
//   slots are read only once they have been written.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module deque_with_value_search
    import dqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic signed [31:0]   s_tdata,   // [31:0] value
    input  wire logic [2:0]           s_tuser,   // [2:0] func
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [15:0]               m_tdata,   // [4:0] position, [9:5] entry_count
    output logic [1:0]                m_tuser    // [1:0] status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 2;
    localparam int M_PAD = 16 - 2 * POS_W;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

    // Sequencer and queue state
    state_t                     state_reg, state_next;
    logic [PTR_W-1:0]           front_reg, front_next;
    logic [CNT_W-1:0]           count_reg, count_next;

    // Search context: slot and index of the entry now on the read port
    logic [PTR_W-1:0]           scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0]           scan_idx_reg, scan_idx_next;
    logic signed [VALUE_W-1:0]  value_reg, value_next;

    // Result held until the output register is free
    status_t                    res_status_reg, res_status_next;
    logic [CNT_W-1:0]           res_pos_reg, res_pos_next;

    // Output register
    logic                       m_valid_reg, m_valid_next;
    status_t                    m_status_reg, m_status_next;
    logic [POS_W-1:0]           m_pos_reg, m_pos_next;
    logic [POS_W-1:0]           m_count_reg, m_count_next;

    // Ring memory port
    logic                       ram_we;
    logic [PTR_W-1:0]           ram_waddr;
    logic [VALUE_W-1:0]         ram_wdata;
    logic [PTR_W-1:0]           ram_raddr;
    logic [VALUE_W-1:0]         rd_data;

    logic                       in_accept;
    func_t                      in_func;
    logic                       in_search;
    logic                       scan_busy;
    logic [PTR_W-1:0]           front_dec;
    logic [PTR_W-1:0]           front_inc;
    logic [SUM_W-1:0]           back_sum;
    logic [PTR_W-1:0]           back_slot;
    logic [PTR_W-1:0]           scan_inc;
    logic                       is_match;
    logic                       scan_last;
    logic                       out_free;
    logic                       is_full;
    logic                       is_empty;

    dqs_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (VALUE_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (rd_data)
    );

    assign in_accept = s_tvalid && s_tready;
    assign in_func   = func_t'(s_tuser);
    assign in_search = (in_func == FN_SEARCH);
    assign scan_busy = (state_reg == S_SCAN);
    assign is_full   = (count_reg == FULL_CNT);
    assign is_empty  = (count_reg == '0);

    // Ring pointer arithmetic: wrap at DEPTH, which need not be a power of two
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - PTR_W'(1);
    assign front_inc = (front_reg == LAST_SLOT) ? '0 : front_reg + PTR_W'(1);
    assign scan_inc  = (scan_ptr_reg == LAST_SLOT) ? '0 : scan_ptr_reg + PTR_W'(1);
    assign back_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign back_slot = (back_sum >= DEPTH_SUM) ? PTR_W'(back_sum - DEPTH_SUM)
                                               : PTR_W'(back_sum);

    // The shared comparator: one stored entry against the search value per cycle
    assign is_match  = (rd_data == $unsigned(value_reg));
    assign scan_last = ((scan_idx_reg + CNT_W'(1)) == count_reg);
    assign out_free  = !m_valid_reg || m_tready;

    assign ram_wdata = $unsigned(s_tdata);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    if (in_search && !is_empty) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_SCAN: begin
                if (is_match || scan_last) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb begin
        s_tready        = (state_reg == S_IDLE);
        ram_we          = 1'b0;
        ram_waddr       = front_dec;
        ram_raddr       = scan_busy ? scan_inc : front_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        scan_ptr_next   = scan_ptr_reg;
        scan_idx_next   = scan_idx_reg;
        value_next      = value_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        // Drop the held transaction once the receiver takes it
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_pos_next      = m_pos_reg;
        m_count_next    = m_count_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    value_next      = s_tdata;
                    scan_ptr_next   = front_reg;
                    scan_idx_next   = '0;
                    res_pos_next    = '0;
                    res_status_next = STS_OK;
                    case (in_func)
                        FN_PUSH_FRONT: begin
                            if (is_full) begin
                                res_status_next = STS_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = front_dec;
                                front_next = front_dec;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FN_PUSH_BACK: begin
                            if (is_full) begin
                                res_status_next = STS_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = back_slot;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FN_POP_FRONT: begin
                            if (is_empty) begin
                                res_status_next = STS_EMPTY;
                            end else begin
                                front_next = front_inc;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        FN_POP_BACK: begin
                            if (is_empty) begin
                                res_status_next = STS_EMPTY;
                            end else begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        FN_SEARCH: begin
                            // Cleared on the first match
                            res_status_next = STS_NOT_FOUND;
                        end
                        default: begin
                            res_status_next = STS_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (is_match) begin
                    res_status_next = STS_OK;
                    res_pos_next    = scan_idx_reg + CNT_W'(1);
                end else if (!scan_last) begin
                    scan_ptr_next = scan_inc;
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_pos_next    = POS_W'(res_pos_reg);
                    m_count_next  = POS_W'(count_reg);
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        scan_ptr_reg   <= scan_ptr_next;
        scan_idx_reg   <= scan_idx_next;
        value_reg      <= value_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        m_status_reg   <= m_status_next;
        m_pos_reg      <= m_pos_next;
        m_count_reg    <= m_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD{1'b0}}, m_count_reg, m_pos_reg};
    assign m_tuser  = m_status_reg;

    // The count never runs past the ring size
    `ASSERT_NEVER(a_count_bound, aclk, aresetn, count_reg > FULL_CNT, "count exceeds depth")
    // The scan never reaches beyond the live entries
    `ASSERT_CLK(a_scan_range, aclk, aresetn, scan_busy |-> scan_idx_reg < count_reg, "scan overrun")
    // A push, pop or unused code goes straight to the result step
    `ASSERT_CLK(a_update, aclk, aresetn, in_accept && !in_search |=> !scan_busy, "update overran")

endmodule

`default_nettype wire

// File: rtl/dqs_ram.sv
// Ring storage for the deque: one write port, one read port, registered read.
// Depends on dqs_pkg for the default depth and the value width.
`timescale 1ns / 1ps
`default_nettype none

module dqs_ram
    import dqs_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = VALUE_W
) (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire logic [DATA_W-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic      [DATA_W-1:0]         rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write and read share the clock; contents need no reset.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for deque_with_value_search: drives requests on the s_
// stream, predicts every result from a local copy of the ring, checks the m_ stream.
// Depends on dqs_pkg and the RTL of the block.
module tb_top
    import dqs_pkg::*;
();

    localparam int DEPTH       = DEPTH_DEF;
    localparam int IDLE_LIMIT  = 2000;       // cycles with no transaction on either side
    localparam int LONG_HOLD   = 300;        // long receiver hold-off, well under the limit
    localparam int TAIL_CYCLES = DEPTH + 8;  // longest search plus margin

    // Codes 5 to 7 are unused operations: the block answers them as no-ops
    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    localparam logic [VALUE_W-1:0] VAL_MAX      = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VAL_MIN      = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [VALUE_W-1:0] VAL_ABSENT   = 32'h0001_2345;

    typedef struct packed {
        status_t          status;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] count;
    } outcome_t;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_MOSTLY,
        SINK_CYCLIC
    } sink_style_t;

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      s_tvalid = 1'b0;
    wire                       s_tready;
    logic signed [VALUE_W-1:0] s_tdata  = '0;
    logic [FUNC_W-1:0]         s_tuser  = '0;
    wire                       m_tvalid;
    logic                      m_tready = 1'b0;
    wire [15:0]                m_tdata;
    wire [STATUS_W-1:0]        m_tuser;

    // Local image of the ring: slot contents, front slot and entry count
    logic [VALUE_W-1:0] ring_image [DEPTH];
    int                 front_slot = 0;
    int                 live_count = 0;

    outcome_t expected_results[$];
    int       error_count   = 0;
    int       burst_left    = 0;
    int       sink_hold_req = 0;

    deque_with_value_search #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Apply one accepted request to the ring image and return the result it
    // must produce. Searches walk the live entries from the front only.
    function automatic outcome_t apply_request(logic [FUNC_W-1:0] fn,
                                               logic [VALUE_W-1:0] val);
        outcome_t res;
        int       i;
        bit       hit;
        res.status   = STS_OK;
        res.position = '0;
        hit          = 1'b0;
        case (fn)
            FN_PUSH_FRONT: begin
                if (live_count >= DEPTH) begin
                    res.status = STS_FULL;
                end else begin
                    front_slot = (front_slot + DEPTH - 1) % DEPTH;
                    ring_image[front_slot] = val;
                    live_count++;
                end
            end
            FN_PUSH_BACK: begin
                if (live_count >= DEPTH) begin
                    res.status = STS_FULL;
                end else begin
                    ring_image[(front_slot + live_count) % DEPTH] = val;
                    live_count++;
                end
            end
            FN_POP_FRONT: begin
                if (live_count == 0) begin
                    res.status = STS_EMPTY;
                end else begin
                    front_slot = (front_slot + 1) % DEPTH;
                    live_count--;
                end
            end
            FN_POP_BACK: begin
                if (live_count == 0) res.status = STS_EMPTY;
                else live_count--;
            end
            FN_SEARCH: begin
                res.status = STS_NOT_FOUND;
                for (i = 0; i < live_count && !hit; i++) begin
                    if (ring_image[(front_slot + i) % DEPTH] == val) begin
                        hit          = 1'b1;
                        res.status   = STS_OK;
                        res.position = POS_W'(i + 1);
                    end
                end
            end
            default: ;
        endcase
        res.count = POS_W'(live_count);
        return res;
    endfunction

    // Often a small pool so that searches hit and duplicates occur; some
    // extremes; the rest fully random so every bit toggles.
    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4) return VALUE_W'($urandom_range(0, 7)) - 32'd3;
        if (roll == 4) begin
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return '0;
                default: return VAL_ALL_ONES;
            endcase
        end
        return $urandom;
    endfunction

    // Search keys: usually a live entry, so positions across the whole ring occur
    function automatic logic [VALUE_W-1:0] pick_key();
        if (live_count > 0 && $urandom_range(0, 9) < 6)
            return ring_image[(front_slot + $urandom_range(0, live_count - 1)) % DEPTH];
        return pick_value();
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func(int push_pct, int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) return FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
        if (roll < 4 + push_pct) return $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
        if (roll < 4 + push_pct + pop_pct) return $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK;
        return FN_SEARCH;
    endfunction

    // Offer one request and hold it until the transaction completes. Entered
    // just after a rising edge; the sender runs in bursts with gaps between.
    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [VALUE_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(30, 80);
            else burst_left = $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= val;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        expected_results.push_back(apply_request(fn, val));
    endtask

    task automatic send_random(input int push_pct, input int pop_pct);
        logic [FUNC_W-1:0] fn;
        fn = pick_func(push_pct, pop_pct);
        send_request(fn, (fn == FN_SEARCH) ? pick_key() : pick_value());
    endtask

    // Drop valid and wait until every outstanding result has arrived
    task automatic drain_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Empty-store cases, unused codes, extreme values, every operation,
    // first-match on a duplicate, then back to empty
    task automatic test_directed_cases();
        send_request(FN_POP_FRONT, VAL_ALL_ONES);
        send_request(FN_POP_BACK, VAL_MIN);
        send_request(FN_SEARCH, '0);
        send_request(FN_SPARE_LO, VAL_ALL_ONES);
        send_request(FN_SPARE_LO + 3'd1, VAL_MIN);
        send_request(FN_SPARE_HI, VAL_MAX);
        send_request(FN_PUSH_BACK, VAL_MAX);
        send_request(FN_PUSH_FRONT, VAL_MIN);
        send_request(FN_PUSH_BACK, '0);
        send_request(FN_PUSH_FRONT, VAL_ALL_ONES);
        send_request(FN_SEARCH, VAL_MAX);
        send_request(FN_SEARCH, VAL_MIN);
        send_request(FN_SEARCH, VAL_ALL_ONES);
        send_request(FN_SEARCH, VAL_ABSENT);
        send_request(FN_PUSH_BACK, VAL_ALL_ONES);
        send_request(FN_SEARCH, VAL_ALL_ONES);
        send_request(FN_POP_FRONT, '0);
        send_request(FN_SEARCH, VAL_ALL_ONES);
        send_request(FN_POP_BACK, '0);
        send_request(FN_POP_BACK, '0);
        send_request(FN_POP_FRONT, '0);
        send_request(FN_POP_FRONT, '0);
        send_request(FN_POP_FRONT, '0);
        send_request(FN_SEARCH, '0);
    endtask

    // Fill to full with searches mixed in, push past full, then drain past empty
    task automatic test_fill_and_drain();
        int round;
        for (round = 0; round < 4; round++) begin
            while (live_count < DEPTH) send_random(75, 0);
            repeat ($urandom_range(1, 3))
                send_request($urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK, pick_value());
            send_request(FN_SEARCH, pick_key());
            while (live_count > 0) send_random(0, 75);
            repeat ($urandom_range(1, 3))
                send_request($urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK, pick_value());
        end
    endtask

    // Hold the receiver off for a long stretch while requests keep coming,
    // so that both result slots fill and s_tready drops
    task automatic test_output_stall();
        sink_hold_req = LONG_HOLD;
        repeat (40) send_random(40, 25);
    endtask

    // Random mix in phases with drifting push/pop balance
    task automatic test_random_mix();
        int phase;
        int push_pct;
        for (phase = 0; phase < 12; phase++) begin
            push_pct = $urandom_range(20, 50);
            repeat (50) send_random(push_pct, 60 - push_pct);
        end
    endtask

    // Receiver: stall on a pattern of its own, switching style every stretch;
    // a long hold-off request takes priority and is counted here
    initial begin : result_sink
        int          hold_left;
        int          stretch_left;
        int          phase;
        sink_style_t style;
        hold_left    = 0;
        stretch_left = 0;
        phase        = 0;
        style        = SINK_OPEN;
        forever begin
            @(posedge aclk);
            if (sink_hold_req != 0) begin
                hold_left     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    style        = sink_style_t'($urandom_range(0, 3));
                    stretch_left = $urandom_range(10, 80);
                end
                stretch_left--;
                phase++;
                case (style)
                    SINK_OPEN:   m_tready <= 1'b1;
                    SINK_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
                    SINK_MOSTLY: m_tready <= ($urandom_range(0, 4) != 0);
                    default:     m_tready <= ((phase % 7) >= 3);
                endcase
            end
        end
    end

    // Compare every result transaction with the oldest expectation
    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing outstanding: m_tuser=%0d m_tdata=%h",
                       m_tuser, m_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[POS_W-1:0] !== want.position) begin
                    $error("position: expected %0d, actual %0d",
                           want.position, m_tdata[POS_W-1:0]);
                    error_count++;
                end
                if (m_tdata[2*POS_W-1:POS_W] !== want.count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           want.count, m_tdata[2*POS_W-1:POS_W]);
                    error_count++;
                end
            end
        end
    end

    // Abort when neither side has moved a transaction for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus_main
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        drain_results();
        test_fill_and_drain();
        drain_results();
        test_output_stall();
        drain_results();
        test_random_mix();
        drain_results();
        // Allow any stray result to surface before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/dqs_pkg.sv
rtl/dqs_ram.sv
rtl/deque_with_value_search.sv
bench/tb_top.sv
